FILE: src/cmtg_pkg.sv
// ----------------------------------------------------------------------------
// cmtg_pkg
// Shared constants, types and helper functions of the cell mean threshold grid.
// ----------------------------------------------------------------------------
package cmtg_pkg;

  // grid geometry
  localparam int GRID_CELLS     = 10;
  localparam int MAX_CELL_WIDTH = 32;

  // field widths
  localparam int PIX_W   = 8;
  localparam int THR_W   = 8;
  localparam int CW_W    = 6;
  localparam int IDX_W   = 4;
  localparam int POS_W   = 9;
  // sums keep growing across width writes, so they wrap only at 32 bits
  localparam int SUM_W   = 32;
  localparam int W2_W    = 2 * CW_W;
  localparam int LIMIT_W = 19;
  localparam int REM_W   = CW_W + 1;

  // divider sequencing for position resync
  localparam int DIV_CNT_W = 4;

  // result queue
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;
  localparam int CRED_W     = FIFO_AW + 1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);
  localparam logic [CW_W-1:0]  CW_RESET  = CW_W'(8);
  localparam logic [IDX_W-1:0] GRID_LAST = IDX_W'(GRID_CELLS - 1);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_CELL_WIDTH = 2'd1
  } cfg_idx_e;

  // word travelling along the cell chain
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             emit;
    logic             last;
    logic             clr;
    logic             res;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [PIX_W-1:0] pix;
  } tok_t;

  // one result word
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             res;
    logic             last;
  } res_t;

  // clamp the programmed cell width to 1..MAX_CELL_WIDTH
  function automatic logic [CW_W-1:0] eff_width(input logic [CW_W-1:0] cw);
    logic [CW_W-1:0] w;
    w = cw;
    if (cw == '0) begin
      w = CW_W'(1);
    end else if (cw > CW_W'(MAX_CELL_WIDTH)) begin
      w = CW_W'(MAX_CELL_WIDTH);
    end
    return w;
  endfunction

  // one restoring division step: returns {remainder, quotient}
  function automatic logic [REM_W+POS_W-1:0] div_step(input logic [REM_W-1:0] rem,
                                                      input logic [POS_W-1:0] quo,
                                                      input logic [CW_W-1:0]  dvs);
    logic [REM_W-1:0] r;
    logic [POS_W-1:0] q;
    r = {rem[REM_W-2:0], quo[POS_W-1]};
    q = {quo[POS_W-2:0], 1'b0};
    if (r >= {1'b0, dvs}) begin
      r    = r - {1'b0, dvs};
      q[0] = 1'b1;
    end
    return {r, q};
  endfunction

endpackage

FILE: src/cmtg_pix_if.sv
// ----------------------------------------------------------------------------
// cmtg_pix_if
// Pixel stream channel: valid/ready with pixel and frame start flag.
// ----------------------------------------------------------------------------
interface cmtg_pix_if import cmtg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

FILE: src/cmtg_res_if.sv
// ----------------------------------------------------------------------------
// cmtg_res_if
// Cell result channel: valid/ready with grid position, bit and last flag.
// ----------------------------------------------------------------------------
interface cmtg_res_if import cmtg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cell_row;
  logic [IDX_W-1:0] cell_col;
  logic             cell_bit;
  logic             last_cell;

  modport source (output valid, output cell_row, output cell_col, output cell_bit,
                  output last_cell, input ready);
  modport sink   (input valid, input cell_row, input cell_col, input cell_bit,
                  input last_cell, output ready);
endinterface

FILE: src/cmtg_cfg_if.sv
// ----------------------------------------------------------------------------
// cmtg_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface cmtg_cfg_if import cmtg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/cell_mean_threshold_grid_top.sv
// ----------------------------------------------------------------------------
// cell_mean_threshold_grid_top
// Block mean binarization of a square greyscale image on a grid of cells.
// ----------------------------------------------------------------------------
// in_i carries one pixel word per handshake in raster order; frame_start marks
// the first pixel of an image. out_o carries one word per finished cell, at
// its bottom-right pixel: grid row, grid column, the threshold bit and a flag
// on the final cell. cfg_i writes threshold (index 0) and cell width (index 1)
// and is always ready.
// Throughput is one pixel per cycle while no resync, configuration write or
// full credit count holds in_i not ready. A pixel word runs through a
// registered position stage and a chain of ten registered column cells.
// A cell width write re-derives the cell position by a 9-step divider, and
// in_i is held not ready until the divider finishes.
// Reset restores threshold 128 and cell width 8, clears all sums and puts the
// position at the origin. When the receiver stalls, results collect in a
// 16-word queue; in_i stays ready while fewer than 16 words are in flight or
// queued, so pixels keep flowing across short stalls.
// ----------------------------------------------------------------------------
module cell_mean_threshold_grid_top import cmtg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cmtg_pix_if.sink   in_i,
  cmtg_res_if.source out_o,
  cmtg_cfg_if.sink   cfg_i
);

  logic [THR_W-1:0]   thr_q;
  logic [CW_W-1:0]    cw_q;
  logic [CW_W-1:0]    width;
  logic [W2_W-1:0]    w2_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [CRED_W-1:0]  used_q;
  logic               cfg_acc, in_acc, resync, busy, push, drop, pop;
  tok_t               chain [GRID_CELLS+1];
  tok_t               tail;
  res_t               push_data, head;

  // configuration registers
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign resync      = cfg_acc && (cfg_i.index == CFG_CELL_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      cw_q  <= CW_RESET;
    end else if (cfg_acc) begin
      if (cfg_i.index == CFG_THRESHOLD) begin
        thr_q <= cfg_i.data[THR_W-1:0];
      end else if (cfg_i.index == CFG_CELL_WIDTH) begin
        cw_q <= cfg_i.data[CW_W-1:0];
      end
    end
  end

  assign width = eff_width(cw_q);

  // limit = (threshold + 1) * width^2, one multiply per stage
  always_ff @(posedge clk_i) begin
    w2_q    <= W2_W'(width * width);
    limit_q <= LIMIT_W'(({1'b0, thr_q} + (THR_W+1)'(1)) * w2_q);
  end

  // input handshake and word credits
  assign in_i.ready = !busy && !cfg_i.valid && (used_q < CRED_W'(FIFO_DEPTH));
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_q + CRED_W'(in_acc) - CRED_W'(drop) - CRED_W'(pop);
    end
  end

  // position stage
  cmtg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (in_acc),
    .pixel_i       (in_i.pixel),
    .frame_start_i (in_i.frame_start),
    .width_i       (width),
    .resync_i      (resync),
    .busy_o        (busy),
    .tok_o         (chain[0])
  );

  // chain of column cells
  for (genvar g = 0; g < GRID_CELLS; g++) begin : g_cell
    cmtg_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(g)),
      .limit_i (limit_q),
      .tok_i   (chain[g]),
      .tok_o   (chain[g+1])
    );
  end

  // end of chain into the result queue
  assign tail           = chain[GRID_CELLS];
  assign push           = tail.valid && tail.emit;
  assign drop           = tail.valid && !tail.emit;
  assign push_data.row  = tail.row;
  assign push_data.col  = tail.col;
  assign push_data.res  = tail.res;
  assign push_data.last = tail.last;
  assign pop            = out_o.valid && out_o.ready;

  cmtg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .valid_o (out_o.valid),
    .data_o  (head)
  );

  assign out_o.cell_row  = head.row;
  assign out_o.cell_col  = head.col;
  assign out_o.cell_bit  = head.res;
  assign out_o.last_cell = head.last;

  // credits never exceed the queue depth
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CRED_W'(FIFO_DEPTH))
    else $error("word credits exceed queue depth");

  // no pixel taken while the position is being re-derived
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_acc)
    else $error("pixel accepted during position resync");

  // a result word pushed from the chain always holds a credit
  a_push_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (used_q != '0))
    else $error("result pushed without a credit");

  // final cell sits at the bottom-right corner
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last_cell) |->
      ((out_o.cell_row == GRID_LAST) && (out_o.cell_col == GRID_LAST)))
    else $error("last cell flag away from the corner");

endmodule

FILE: src/cmtg_front.sv
// ----------------------------------------------------------------------------
// cmtg_front
// Raster position tracker: splits the pixel position into cell index and
// offset inside the cell, and re-derives both by division after a width write.
// ----------------------------------------------------------------------------
module cmtg_front import cmtg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             frame_start_i,
  input  logic [CW_W-1:0]  width_i,
  input  logic             resync_i,
  output logic             busy_o,
  output tok_t             tok_o
);

  logic [POS_W-1:0]     px_q, px_d, py_q, py_d;
  logic [CW_W-1:0]      xin_q, xin_d, yin_q, yin_d;
  logic [IDX_W-1:0]     col_q, col_d, row_q, row_d;
  logic                 xoob_q, xoob_d, yoob_q, yoob_d;
  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0]     xr_q, xr_d, yr_q, yr_d;
  logic [POS_W-1:0]     xqu_q, xqu_d, yqu_q, yqu_d;
  tok_t                 tok_q, tok_d;

  logic [POS_W-1:0]       cpx, cpy;
  logic [CW_W-1:0]        cxin, cyin, wlast;
  logic [IDX_W-1:0]       ccol, crow;
  logic                   cxoob, cyoob, xend, yend, wrapx, wrapy;
  logic [REM_W+POS_W-1:0] xstep, ystep;

  assign wlast = width_i - CW_W'(1);

  // current position, frame start puts this pixel at the origin
  always_comb begin
    cpx   = frame_start_i ? '0 : px_q;
    cpy   = frame_start_i ? '0 : py_q;
    cxin  = frame_start_i ? '0 : xin_q;
    cyin  = frame_start_i ? '0 : yin_q;
    ccol  = frame_start_i ? '0 : col_q;
    crow  = frame_start_i ? '0 : row_q;
    cxoob = frame_start_i ? 1'b0 : xoob_q;
    cyoob = frame_start_i ? 1'b0 : yoob_q;
    xend  = (cxin == wlast);
    yend  = (cyin == wlast);
    wrapx = cxoob || ((ccol == GRID_LAST) && xend);
    wrapy = cyoob || ((crow == GRID_LAST) && yend);
  end

  // divider steps for the resync
  assign xstep = div_step(xr_q, xqu_q, width_i);
  assign ystep = div_step(yr_q, yqu_q, width_i);

  // position update and resync sequencing
  always_comb begin
    px_d   = px_q;
    py_d   = py_q;
    xin_d  = xin_q;
    yin_d  = yin_q;
    col_d  = col_q;
    row_d  = row_q;
    xoob_d = xoob_q;
    yoob_d = yoob_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    xr_d   = xr_q;
    yr_d   = yr_q;
    xqu_d  = xqu_q;
    yqu_d  = yqu_q;

    tok_d       = tok_q;
    tok_d.valid = acc_i;
    tok_d.hit   = !cxoob && !cyoob;
    tok_d.emit  = !cxoob && !cyoob && xend && yend;
    tok_d.last  = (ccol == GRID_LAST) && (crow == GRID_LAST);
    tok_d.clr   = frame_start_i;
    tok_d.res   = 1'b0;
    tok_d.row   = crow;
    tok_d.col   = ccol;
    tok_d.pix   = pixel_i;

    if (resync_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(POS_W);
      xr_d   = '0;
      yr_d   = '0;
      xqu_d  = px_q;
      yqu_d  = py_q;
    end else if (busy_q) begin
      {xr_d, xqu_d} = xstep;
      {yr_d, yqu_d} = ystep;
      cnt_d         = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        xin_d  = xstep[POS_W +: CW_W];
        yin_d  = ystep[POS_W +: CW_W];
        col_d  = xstep[IDX_W-1:0];
        row_d  = ystep[IDX_W-1:0];
        xoob_d = (xstep[POS_W-1:0] >= POS_W'(GRID_CELLS));
        yoob_d = (ystep[POS_W-1:0] >= POS_W'(GRID_CELLS));
      end
    end else if (acc_i) begin
      // column advance
      if (wrapx) begin
        px_d   = '0;
        xin_d  = '0;
        col_d  = '0;
        xoob_d = 1'b0;
      end else begin
        px_d   = cpx + POS_W'(1);
        xoob_d = 1'b0;
        if (xend) begin
          xin_d = '0;
          col_d = ccol + IDX_W'(1);
        end else begin
          xin_d = cxin + CW_W'(1);
          col_d = ccol;
        end
      end
      // row advance at the end of a line
      py_d   = cpy;
      yin_d  = cyin;
      row_d  = crow;
      yoob_d = cyoob;
      if (wrapx) begin
        if (wrapy) begin
          py_d   = '0;
          yin_d  = '0;
          row_d  = '0;
          yoob_d = 1'b0;
        end else begin
          py_d = cpy + POS_W'(1);
          if (yend) begin
            yin_d = '0;
            row_d = crow + IDX_W'(1);
          end else begin
            yin_d = cyin + CW_W'(1);
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q   <= '0;
      py_q   <= '0;
      xin_q  <= '0;
      yin_q  <= '0;
      col_q  <= '0;
      row_q  <= '0;
      xoob_q <= 1'b0;
      yoob_q <= 1'b0;
      busy_q <= 1'b0;
      cnt_q  <= '0;
      tok_q  <= '0;
    end else begin
      px_q   <= px_d;
      py_q   <= py_d;
      xin_q  <= xin_d;
      yin_q  <= yin_d;
      col_q  <= col_d;
      row_q  <= row_d;
      xoob_q <= xoob_d;
      yoob_q <= yoob_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      tok_q  <= tok_d;
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    xr_q  <= xr_d;
    yr_q  <= yr_d;
    xqu_q <= xqu_d;
    yqu_q <= yqu_d;
  end

  assign busy_o = busy_q;
  assign tok_o  = tok_q;

endmodule

FILE: src/cmtg_cell.sv
// ----------------------------------------------------------------------------
// cmtg_cell
// One grid column: holds the running sum of its cell in the current band,
// adds matching pixels and decides the cell bit as the word passes through.
// ----------------------------------------------------------------------------
module cmtg_cell import cmtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [IDX_W-1:0]   idx_i,
  input  logic [LIMIT_W-1:0] limit_i,
  input  tok_t               tok_i,
  output tok_t               tok_o
);

  logic [SUM_W-1:0] sum_q, sum_d, base, acc;
  logic             mine;
  tok_t             tok_q, tok_d;

  // accumulate and compare
  always_comb begin
    base  = tok_i.clr ? '0 : sum_q;
    acc   = base + SUM_W'(tok_i.pix);
    mine  = tok_i.valid && tok_i.hit && (tok_i.col == idx_i);
    sum_d = sum_q;
    tok_d = tok_i;
    if (tok_i.valid) begin
      sum_d = base;
      if (mine) begin
        sum_d = tok_i.emit ? '0 : acc;
        if (tok_i.emit) begin
          tok_d.res = (acc >= SUM_W'(limit_i));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      tok_q <= '0;
    end else begin
      sum_q <= sum_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: src/cmtg_fifo.sv
// ----------------------------------------------------------------------------
// cmtg_fifo
// Result queue between the cell chain and the output channel.
// ----------------------------------------------------------------------------
module cmtg_fifo import cmtg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  input  logic pop_i,
  output logic valid_o,
  output res_t data_o
);

  res_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [CRED_W-1:0]  cnt_q;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_q + CRED_W'(push_i) - CRED_W'(pop_i);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

endmodule
